FILE: rtl/core/edc_pkg.sv
package edc_pkg;

  // lane order of the four velocity components
  localparam int LANES = 4;
  localparam int LANE_V1X = 0;
  localparam int LANE_V1Y = 1;
  localparam int LANE_V2X = 2;
  localparam int LANE_V2Y = 3;

  // field and datapath widths
  localparam int VW   = 32;  // velocity, position
  localparam int MW   = 31;  // mass
  localparam int DW   = 33;  // position or velocity difference
  localparam int PW   = 66;  // signed product of two differences
  localparam int DOTW = 67;  // signed dot product
  localparam int MAGW = 65;  // dot magnitude
  localparam int SQW  = 65;  // squared distance
  localparam int MSW  = 32;  // mass sum, doubled mass
  localparam int TW   = 97;  // |dot| * |d|
  localparam int DENW = 97;  // mass sum * squared distance
  localparam int NUMW = 129; // numerator of one correction term
  localparam int QW   = 34;  // quotient bits; |term| < 2 * 1.21 * max|dv| < 2^34

  // front end to scaling
  typedef struct packed {
    logic [LANES-1:0][VW-1:0] vel;
    logic                     bad;
    logic [MAGW-1:0]          dotm;
    logic                     dneg;
    logic [VW-1:0]            ax;
    logic [VW-1:0]            ay;
    logic                     xneg;
    logic                     yneg;
    logic [SQW-1:0]           sq;
    logic [MSW-1:0]           msum;
    logic [MSW-1:0]           m1d;
    logic [MSW-1:0]           m2d;
  } fr_t;

  // scaling to divider
  typedef struct packed {
    logic [LANES-1:0][VW-1:0]   vel;
    logic                       bad;
    logic [LANES-1:0][NUMW-1:0] num;
    logic [LANES-1:0]           neg;
    logic [DENW-1:0]            den;
  } sc_t;

  // final result
  typedef struct packed {
    logic [LANES-1:0][VW-1:0] vel;
    logic                     bad;
  } res_t;

endpackage

FILE: rtl/core/elastic_disk_collision_2d.sv
// Channel  Direction  Handshake              Beat
// in_      input      in_valid / in_ready    positions, masses, velocities of two disks
// out_     output     out_valid / out_ready  new velocities and bad_input flag
//
// One beat per cycle while out_ready is high; 3 front, 4 scaling, 34 quotient-bit
// stages and 1 round-and-apply stage; the divider yields one bit per stage.
// Reset (rst_n low, synchronous) clears only the valid bits of every stage.
// Each stage holds while its successor is full and stalled, so bubbles inside the
// pipeline keep in_ready high while a result waits at the output.
module elastic_disk_collision_2d (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [31:0]     in_first_pos_x,
  input  logic signed [31:0]     in_first_pos_y,
  input  logic signed [31:0]     in_second_pos_x,
  input  logic signed [31:0]     in_second_pos_y,
  input  logic [30:0]            in_first_mass,
  input  logic [30:0]            in_second_mass,
  input  logic signed [31:0]     in_first_vel_x,
  input  logic signed [31:0]     in_first_vel_y,
  input  logic signed [31:0]     in_second_vel_x,
  input  logic signed [31:0]     in_second_vel_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     out_new_first_vel_x,
  output logic signed [31:0]     out_new_first_vel_y,
  output logic signed [31:0]     out_new_second_vel_x,
  output logic signed [31:0]     out_new_second_vel_y,
  output logic                   out_bad_input
);

  logic [edc_pkg::LANES-1:0][edc_pkg::VW-1:0] vel_in;
  edc_pkg::fr_t  fr;
  edc_pkg::sc_t  sc;
  edc_pkg::res_t res;
  logic fr_valid, fr_ready, sc_valid, sc_ready;

  assign vel_in[edc_pkg::LANE_V1X] = in_first_vel_x;
  assign vel_in[edc_pkg::LANE_V1Y] = in_first_vel_y;
  assign vel_in[edc_pkg::LANE_V2X] = in_second_vel_x;
  assign vel_in[edc_pkg::LANE_V2Y] = in_second_vel_y;

  // differences, dot product, squared distance
  edc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .p1x       (in_first_pos_x),
    .p1y       (in_first_pos_y),
    .p2x       (in_second_pos_x),
    .p2y       (in_second_pos_y),
    .m1        (in_first_mass),
    .m2        (in_second_mass),
    .vel       (vel_in),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr)
  );

  // numerators and denominator
  edc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_data  (sc)
  );

  // four-lane divider with rounding and saturation
  edc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_data   (sc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign out_new_first_vel_x  = res.vel[edc_pkg::LANE_V1X];
  assign out_new_first_vel_y  = res.vel[edc_pkg::LANE_V1Y];
  assign out_new_second_vel_x = res.vel[edc_pkg::LANE_V2X];
  assign out_new_second_vel_y = res.vel[edc_pkg::LANE_V2Y];
  assign out_bad_input        = res.bad;

`ifndef SYNTHESIS
  // an empty output stage frees the whole stall chain
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // internal handoff never stalls while the next module has room
  a_inner_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !sc_valid |-> fr_ready)
    else $error("scaling stage stalled while empty");

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !sc_valid && !fr_valid)
    else $error("valid bits survive reset");
`endif

endmodule

FILE: rtl/core/edc_front.sv
module edc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        p1x,
  input  logic signed [31:0]        p1y,
  input  logic signed [31:0]        p2x,
  input  logic signed [31:0]        p2y,
  input  logic [edc_pkg::MW-1:0]    m1,
  input  logic [edc_pkg::MW-1:0]    m2,
  input  logic [edc_pkg::LANES-1:0][edc_pkg::VW-1:0] vel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output edc_pkg::fr_t              out_data
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  // stage 1: differences and mass sums
  logic signed [edc_pkg::DW-1:0] dx_r, dy_r, dvx_r, dvy_r;
  logic [edc_pkg::MSW-1:0]       msum1_r, m1d1_r, m2d1_r;
  logic                          bad1_r;
  logic [edc_pkg::LANES-1:0][edc_pkg::VW-1:0] vel1_r;

  // stage 2: products and magnitudes
  logic signed [edc_pkg::PW-1:0] px_r, py_r, qx_r, qy_r;
  logic [edc_pkg::VW-1:0]        ax_r, ay_r;
  logic                          xneg_r, yneg_r;
  logic [edc_pkg::MSW-1:0]       msum2_r, m1d2_r, m2d2_r;
  logic                          bad2_r;
  logic [edc_pkg::LANES-1:0][edc_pkg::VW-1:0] vel2_r;

  edc_pkg::fr_t f3_r;

  // elastic stall chain
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v3_r;
  assign out_data  = f3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // magnitude and sign of the position differences
  logic signed [edc_pkg::DW-1:0] ndx, ndy;
  logic [edc_pkg::VW-1:0]        ax_nxt, ay_nxt;
  always_comb begin
    ndx = -dx_r;
    ndy = -dy_r;
    ax_nxt = dx_r[edc_pkg::DW-1] ? ndx[edc_pkg::VW-1:0] : dx_r[edc_pkg::VW-1:0];
    ay_nxt = dy_r[edc_pkg::DW-1] ? ndy[edc_pkg::VW-1:0] : dy_r[edc_pkg::VW-1:0];
  end

  // dot product and squared distance
  logic signed [edc_pkg::DOTW-1:0] dot, ndot;
  logic [edc_pkg::SQW-1:0]         sq_nxt;
  always_comb begin
    dot    = edc_pkg::DOTW'(px_r) + edc_pkg::DOTW'(py_r);
    ndot   = -dot;
    sq_nxt = qx_r[edc_pkg::SQW-1:0] + qy_r[edc_pkg::SQW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx_r    <= $signed({p1x[31], p1x}) - $signed({p2x[31], p2x});
      dy_r    <= $signed({p1y[31], p1y}) - $signed({p2y[31], p2y});
      dvx_r   <= $signed({vel[edc_pkg::LANE_V1X][31], vel[edc_pkg::LANE_V1X]})
               - $signed({vel[edc_pkg::LANE_V2X][31], vel[edc_pkg::LANE_V2X]});
      dvy_r   <= $signed({vel[edc_pkg::LANE_V1Y][31], vel[edc_pkg::LANE_V1Y]})
               - $signed({vel[edc_pkg::LANE_V2Y][31], vel[edc_pkg::LANE_V2Y]});
      msum1_r <= {1'b0, m1} + {1'b0, m2};
      m1d1_r  <= {m1, 1'b0};
      m2d1_r  <= {m2, 1'b0};
      bad1_r  <= (m1 == '0) || (m2 == '0) || ((p1x == p2x) && (p1y == p2y));
      vel1_r  <= vel;
    end
    if (en2) begin
      px_r    <= dvx_r * dx_r;
      py_r    <= dvy_r * dy_r;
      qx_r    <= dx_r * dx_r;
      qy_r    <= dy_r * dy_r;
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      xneg_r  <= dx_r[edc_pkg::DW-1];
      yneg_r  <= dy_r[edc_pkg::DW-1];
      msum2_r <= msum1_r;
      m1d2_r  <= m1d1_r;
      m2d2_r  <= m2d1_r;
      bad2_r  <= bad1_r;
      vel2_r  <= vel1_r;
    end
    if (en3) begin
      f3_r.vel  <= vel2_r;
      f3_r.bad  <= bad2_r;
      f3_r.dotm <= dot[edc_pkg::DOTW-1] ? ndot[edc_pkg::MAGW-1:0] : dot[edc_pkg::MAGW-1:0];
      f3_r.dneg <= dot[edc_pkg::DOTW-1];
      f3_r.ax   <= ax_r;
      f3_r.ay   <= ay_r;
      f3_r.xneg <= xneg_r;
      f3_r.yneg <= yneg_r;
      f3_r.sq   <= sq_nxt;
      f3_r.msum <= msum2_r;
      f3_r.m1d  <= m1d2_r;
      f3_r.m2d  <= m2d2_r;
    end
  end

endmodule

FILE: rtl/core/edc_scale.sv
module edc_scale (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  edc_pkg::fr_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output edc_pkg::sc_t out_data
);

  localparam int L = edc_pkg::LANES;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1: 32-bit partial products of |dot|*|d| and sum*sq
  logic [63:0] alx_r, aly_r, dl_r;
  logic [64:0] ahx_r, ahy_r, dh_r;
  logic [edc_pkg::MSW-1:0] m1d1_r, m2d1_r;
  logic [L-1:0] neg1_r, neg2_r, neg3_r;
  logic bad1_r, bad2_r, bad3_r;
  logic [L-1:0][edc_pkg::VW-1:0] vel1_r, vel2_r, vel3_r;

  // stage 2: assembled products
  logic [edc_pkg::TW-1:0]   tx_r, ty_r;
  logic [edc_pkg::DENW-1:0] den2_r, den3_r;
  logic [edc_pkg::MSW-1:0]  m1d2_r, m2d2_r;

  // stage 3: partial products with the doubled masses
  logic [L-1:0][63:0] p0_r, p1_r;
  logic [L-1:0][64:0] p2_r;

  edc_pkg::sc_t s4_r;

  assign en4       = !v4_r || out_ready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_ready  = en1;
  assign out_valid = v4_r;
  assign out_data  = s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // per-lane operands for the mass products
  logic [L-1:0][edc_pkg::TW-1:0]  tsel;
  logic [L-1:0][edc_pkg::MSW-1:0] msel;
  always_comb begin
    tsel[edc_pkg::LANE_V1X] = tx_r;
    tsel[edc_pkg::LANE_V1Y] = ty_r;
    tsel[edc_pkg::LANE_V2X] = tx_r;
    tsel[edc_pkg::LANE_V2Y] = ty_r;
    msel[edc_pkg::LANE_V1X] = m2d2_r;
    msel[edc_pkg::LANE_V1Y] = m2d2_r;
    msel[edc_pkg::LANE_V2X] = m1d2_r;
    msel[edc_pkg::LANE_V2Y] = m1d2_r;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      alx_r  <= in_data.dotm[31:0] * in_data.ax;
      ahx_r  <= in_data.dotm[edc_pkg::MAGW-1:32] * in_data.ax;
      aly_r  <= in_data.dotm[31:0] * in_data.ay;
      ahy_r  <= in_data.dotm[edc_pkg::MAGW-1:32] * in_data.ay;
      dl_r   <= in_data.sq[31:0] * in_data.msum;
      dh_r   <= in_data.sq[edc_pkg::SQW-1:32] * in_data.msum;
      m1d1_r <= in_data.m1d;
      m2d1_r <= in_data.m2d;
      neg1_r[edc_pkg::LANE_V1X] <= in_data.dneg ^ in_data.xneg;
      neg1_r[edc_pkg::LANE_V1Y] <= in_data.dneg ^ in_data.yneg;
      neg1_r[edc_pkg::LANE_V2X] <= in_data.dneg ^ in_data.xneg;
      neg1_r[edc_pkg::LANE_V2Y] <= in_data.dneg ^ in_data.yneg;
      bad1_r <= in_data.bad;
      vel1_r <= in_data.vel;
    end
    if (en2) begin
      tx_r   <= {ahx_r, 32'b0} + edc_pkg::TW'(alx_r);
      ty_r   <= {ahy_r, 32'b0} + edc_pkg::TW'(aly_r);
      den2_r <= {dh_r, 32'b0} + edc_pkg::DENW'(dl_r);
      m1d2_r <= m1d1_r;
      m2d2_r <= m2d1_r;
      neg2_r <= neg1_r;
      bad2_r <= bad1_r;
      vel2_r <= vel1_r;
    end
    if (en3) begin
      for (int l = 0; l < L; l++) begin
        p0_r[l] <= tsel[l][31:0] * msel[l];
        p1_r[l] <= tsel[l][63:32] * msel[l];
        p2_r[l] <= tsel[l][edc_pkg::TW-1:64] * msel[l];
      end
      den3_r <= den2_r;
      neg3_r <= neg2_r;
      bad3_r <= bad2_r;
      vel3_r <= vel2_r;
    end
    if (en4) begin
      for (int l = 0; l < L; l++) begin
        s4_r.num[l] <= {p2_r[l], 64'b0} + edc_pkg::NUMW'({p1_r[l], 32'b0})
                     + edc_pkg::NUMW'(p0_r[l]);
      end
      s4_r.den <= den3_r;
      s4_r.neg <= neg3_r;
      s4_r.bad <= bad3_r;
      s4_r.vel <= vel3_r;
    end
  end

endmodule

FILE: rtl/core/edc_div.sv
module edc_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  edc_pkg::sc_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output edc_pkg::res_t out_data
);

  localparam int L   = edc_pkg::LANES;
  localparam int NST = edc_pkg::QW;
  localparam int NW  = edc_pkg::NUMW;
  localparam int DNW = edc_pkg::DENW;
  localparam int QW  = edc_pkg::QW;

  // one quotient bit per stage, then a round-and-apply stage
  logic [NST:0]   v_r;
  logic [NST+1:0] en;

  logic [L-1:0][NW-1:0]           rem_r [NST];
  logic [L-1:0][QW-1:0]           q_r   [NST];
  logic [DNW-1:0]                 den_r [NST];
  logic [L-1:0]                   neg_r [NST];
  logic                           bad_r [NST];
  logic [L-1:0][edc_pkg::VW-1:0]  vel_r [NST];

  edc_pkg::res_t res_r;

  assign in_ready  = en[0];
  assign out_valid = v_r[NST];
  assign out_data  = res_r;

  always_comb begin
    en[NST+1] = out_ready;
    for (int k = 0; k <= NST; k++) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k <= NST; k++) begin
        if (en[k]) v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // restoring division stages, most significant quotient bit first
  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int B = NST - 1 - k;
    logic [L-1:0][NW-1:0]          rsrc, rn;
    logic [L-1:0][QW-1:0]          qsrc, qn;
    logic [DNW-1:0]                dsrc;
    logic [L-1:0]                  nsrc;
    logic                          bsrc;
    logic [L-1:0][edc_pkg::VW-1:0] vsrc;
    logic [NW:0]                   dsh;

    if (k == 0) begin : g_first
      assign rsrc = in_data.num;
      assign qsrc = '0;
      assign dsrc = in_data.den;
      assign nsrc = in_data.neg;
      assign bsrc = in_data.bad;
      assign vsrc = in_data.vel;
    end else begin : g_next
      assign rsrc = rem_r[k-1];
      assign qsrc = q_r[k-1];
      assign dsrc = den_r[k-1];
      assign nsrc = neg_r[k-1];
      assign bsrc = bad_r[k-1];
      assign vsrc = vel_r[k-1];
    end

    // shifted divisor kept one bit wider than the remainder
    always_comb begin
      dsh = {{(NW + 1 - DNW){1'b0}}, dsrc} << B;
      for (int l = 0; l < L; l++) begin
        if ({1'b0, rsrc[l]} >= dsh) begin
          rn[l] = rsrc[l] - dsh[NW-1:0];
          qn[l] = qsrc[l] | (QW'(1) << B);
        end else begin
          rn[l] = rsrc[l];
          qn[l] = qsrc[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rn;
        q_r[k]   <= qn;
        den_r[k] <= dsrc;
        neg_r[k] <= nsrc;
        bad_r[k] <= bsrc;
        vel_r[k] <= vsrc;
      end
    end
  end

  function automatic logic [edc_pkg::VW-1:0] sat32(input logic signed [35:0] s);
    logic [edc_pkg::VW-1:0] r;
    if (s > 36'sh0_7FFF_FFFF)       r = 32'h7FFF_FFFF;
    else if (s < -36'sh0_8000_0000) r = 32'h8000_0000;
    else                            r = s[edc_pkg::VW-1:0];
    return r;
  endfunction

  // round half away from zero, apply sign, add and saturate
  logic [L-1:0][QW:0]            qr;
  logic [L-1:0]                  up, neg_eff;
  logic signed [L-1:0][35:0]     term;
  logic [L-1:0][edc_pkg::VW-1:0] vnew;
  always_comb begin
    for (int l = 0; l < L; l++) begin
      up[l]      = {rem_r[NST-1][l][DNW-1:0], 1'b0} >= {1'b0, den_r[NST-1]};
      qr[l]      = {1'b0, q_r[NST-1][l]} + (QW + 1)'(up[l]);
      neg_eff[l] = neg_r[NST-1][l] ^ (l < edc_pkg::LANE_V2X);
      term[l]    = neg_eff[l] ? -$signed({1'b0, qr[l]}) : $signed({1'b0, qr[l]});
      vnew[l]    = sat32($signed({{4{vel_r[NST-1][l][31]}}, vel_r[NST-1][l]}) + term[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      res_r.bad <= bad_r[NST-1];
      res_r.vel <= bad_r[NST-1] ? vel_r[NST-1] : vnew;
    end
  end

endmodule

FILE: test/elastic_disk_collision_2d_tb.sv
module elastic_disk_collision_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] p1x, p1y, p2x, p2y;
    logic [30:0]        m1, m2;
    logic signed [31:0] v1x, v1y, v2x, v2y;
  } pair_t;

  typedef struct {
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic               bad;
  } rebound_t;

  // exact collision response: wide signed math, round half away from zero
  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] round_div(logic signed [191:0] n,
                                                  logic signed [191:0] d);
    logic [191:0] mag, q, r;
    logic         neg;
    neg = n < 0;
    mag = neg ? -n : n;
    q = mag / d;
    r = mag % d;
    if (q >= (192'd1 << 62)) q = 192'd1 << 62;
    else if (2 * r >= d) q = q + 1;
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic rebound_t predict_rebound(pair_t p);
    rebound_t r;
    logic signed [191:0] dx, dy, dvx, dvy, dot, den, k1, k2;
    dx  = 192'(p.p1x) - 192'(p.p2x);
    dy  = 192'(p.p1y) - 192'(p.p2y);
    dvx = 192'(p.v1x) - 192'(p.v2x);
    dvy = 192'(p.v1y) - 192'(p.v2y);
    if (p.m1 == 0 || p.m2 == 0 || (dx == 0 && dy == 0)) begin
      r.v1x = p.v1x; r.v1y = p.v1y; r.v2x = p.v2x; r.v2y = p.v2y;
      r.bad = 1'b1;
      return r;
    end
    dot = dvx * dx + dvy * dy;
    den = (192'(p.m1) + 192'(p.m2)) * (dx * dx + dy * dy);
    k1 = 2 * 192'(p.m2) * dot;
    k2 = 2 * 192'(p.m1) * dot;
    r.v1x = sat32(64'(p.v1x) - round_div(k1 * dx, den));
    r.v1y = sat32(64'(p.v1y) - round_div(k1 * dy, den));
    r.v2x = sat32(64'(p.v2x) + round_div(k2 * dx, den));
    r.v2y = sat32(64'(p.v2y) + round_div(k2 * dy, den));
    r.bad = 1'b0;
    return r;
  endfunction

  class rebound_board;
    rebound_t pending[$];
    int mismatches = 0;
    int checked = 0;
    int bad_seen = 0;

    function void note_pair(pair_t p);
      pending.push_back(predict_rebound(p));
    endfunction

    function void check_rebound(rebound_t got);
      rebound_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      if (got.bad) bad_seen++;
      if (got.v1x !== e.v1x || got.v1y !== e.v1y || got.v2x !== e.v2x ||
          got.v2y !== e.v2y || got.bad !== e.bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch beat %0d: exp %h %h %h %h bad=%b got %h %h %h %h bad=%b",
                   checked, e.v1x, e.v1y, e.v2x, e.v2y, e.bad,
                   got.v1x, got.v1y, got.v2x, got.v2y, got.bad);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [31:0] in_first_pos_x = 0, in_first_pos_y = 0;
  logic signed [31:0] in_second_pos_x = 0, in_second_pos_y = 0;
  logic [30:0] in_first_mass = 0, in_second_mass = 0;
  logic signed [31:0] in_first_vel_x = 0, in_first_vel_y = 0;
  logic signed [31:0] in_second_vel_x = 0, in_second_vel_y = 0;
  logic signed [31:0] out_new_first_vel_x, out_new_first_vel_y;
  logic signed [31:0] out_new_second_vel_x, out_new_second_vel_y;
  logic out_bad_input;

  rebound_board board = new();
  bit sent_all = 0;
  int no_idle = 0;

  elastic_disk_collision_2d DUT (.*);

  initial forever #2 clk = ~clk;

  // gap length, with whole stretches of back-to-back traffic
  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  // valid drops only for a real gap, so back-to-back beats keep it high
  task automatic send_pair(pair_t p);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first_pos_x  <= p.p1x; in_first_pos_y  <= p.p1y;
    in_second_pos_x <= p.p2x; in_second_pos_y <= p.p2y;
    in_first_mass   <= p.m1;  in_second_mass  <= p.m2;
    in_first_vel_x  <= p.v1x; in_first_vel_y  <= p.v1y;
    in_second_vel_x <= p.v2x; in_second_vel_y <= p.v2y;
    do @(posedge clk); while (!in_ready);
    board.note_pair(p);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 512) - 256;
      3: return {{12{$urandom_range(0,1) == 1}}, 20'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(1, 4));
      3, 4: return 31'($urandom_range(1, 32'h0010_0000));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.p1x = rand_word(); p.p1y = rand_word();
    p.p2x = rand_word(); p.p2y = rand_word();
    if ($urandom_range(0, 29) == 0) begin
      p.p2x = p.p1x; p.p2y = p.p1y;
    end else if ($urandom_range(0, 3) == 0) begin
      // nearby disks, the realistic case
      p.p2x = p.p1x + ($urandom_range(0, 32'h40000) - 32'h20000);
      p.p2y = p.p1y + ($urandom_range(0, 32'h40000) - 32'h20000);
    end
    p.m1 = rand_mass(); p.m2 = rand_mass();
    p.v1x = rand_word(); p.v1y = rand_word();
    p.v2x = rand_word(); p.v2y = rand_word();
    return p;
  endfunction

  function automatic pair_t make_pair(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                      logic [31:0] d, logic [30:0] m1, logic [30:0] m2,
                                      logic [31:0] e, logic [31:0] f, logic [31:0] g,
                                      logic [31:0] h);
    pair_t p;
    p.p1x = a; p.p1y = b; p.p2x = c; p.p2y = d; p.m1 = m1; p.m2 = m2;
    p.v1x = e; p.v1y = f; p.v2x = g; p.v2y = h;
    return p;
  endfunction

  // stimulus
  initial begin
    pair_t p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // head-on, equal masses
    send_pair(make_pair(32'h10000, 0, 0, 0, 31'h10000, 31'h10000,
                        -32'sh10000, 0, 32'h10000, 0));
    // zero masses and coincident positions
    send_pair(make_pair(5, 6, 7, 8, 0, 31'h10000, 1, 2, 3, 4));
    send_pair(make_pair(5, 6, 7, 8, 31'h10000, 0, 1, 2, 3, 4));
    send_pair(make_pair(9, 9, 9, 9, 31'h10000, 31'h10000, 1, 2, 3, 4));
    send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    // extremes driving saturation
    send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                        31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000));
    send_pair(make_pair(32'h80000000, 0, 32'h7fffffff, 0, 31'h7fffffff, 31'd1,
                        32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send_pair(make_pair(0, 1, 0, 0, 31'd1, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000));
    send_pair(make_pair(1, 0, 0, 0, 31'd1, 31'd1, 0, 0, 0, 0));
    send_pair(make_pair(1, 1, 0, 0, 31'd3, 31'd1, 1, 0, 0, 0));
    send_pair(make_pair(32'hffffffff, 32'hffffffff, 0, 0, 31'h7fffffff, 31'h7fffffff,
                        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    // oblique hit with largest relative velocity, widest correction term
    send_pair(make_pair(32'h0006_a09e, 32'h0002_c1b8, 0, 0, 31'd1, 31'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000));
    for (int i = 0; i < 1340; i++) begin
      if (i % 300 == 150) no_idle = 1;
      if (i % 300 == 250) no_idle = 0;
      send_pair(rand_pair());
    end
    no_idle = 0;
    in_valid <= 1'b0;
    sent_all = 1;
  end

  // result side with random backpressure
  initial begin
    rebound_t r;
    int stall;
    wait (rst_n);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      r.v1x = out_new_first_vel_x; r.v1y = out_new_first_vel_y;
      r.v2x = out_new_second_vel_x; r.v2y = out_new_second_vel_y;
      r.bad = out_bad_input;
      board.check_rebound(r);
    end
  end

  // end of run
  initial begin
    wait (sent_all);
    wait (board.pending.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d collision beats, %0d flagged as bad input",
             board.checked, board.bad_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/edc_pkg.sv
rtl/core/edc_front.sv
rtl/core/edc_scale.sv
rtl/core/edc_div.sv
rtl/core/elastic_disk_collision_2d.sv
test/elastic_disk_collision_2d_tb.sv
